// ----- design/bsf_pkg.sv -----
package bsf_pkg;

    // Coefficient registers are signed Q2.18, fixed by the register map
    localparam int COEF_BITS = 20;
    localparam int CFG_INDEX_BITS = 3;

    // Register map
    localparam logic [CFG_INDEX_BITS-1:0] CFG_LOW_B0       = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_LOW_A1       = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_LOW_A2       = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_HIGH_B0      = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_HIGH_A1      = 3'd4;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_HIGH_A2      = 3'd5;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_FOURTH_ORDER = 3'd6;

    // Item kinds
    localparam logic KIND_SAMPLE = 1'b0;
    localparam logic KIND_CLEAR  = 1'b1;

    // Section codes in processing order; bit 0 is the branch, bit 1 the stage
    localparam logic [1:0] SEC_LP1 = 2'd0;
    localparam logic [1:0] SEC_HP1 = 2'd1;
    localparam logic [1:0] SEC_LP2 = 2'd2;
    localparam logic [1:0] SEC_HP2 = 2'd3;

    // MAC step counter: five products, then one trailing accumulate
    localparam logic [2:0] MAC_LAST = 3'd5;

    typedef enum logic [2:0] {
        TERM_X0 = 3'd0,
        TERM_X1 = 3'd1,
        TERM_X2 = 3'd2,
        TERM_Y1 = 3'd3,
        TERM_Y2 = 3'd4
    } term_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MAC,
        ST_ROUND,
        ST_CLEAR,
        ST_SUM
    } state_t;

    typedef struct packed {
        logic       load_x;
        logic       clear;
        logic       mul_en;
        term_t      term;
        logic [1:0] sec;
        logic       acc_en;
        logic       acc_first;
        logic       round_en;
        logic       sum_en;
    } cmd_t;

    typedef struct packed {
        logic cascade;
    } sts_t;

endpackage

// ----- design/bsf_ctrl.sv -----
module bsf_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  logic           kind,
    output logic           out_valid,
    input  logic           out_ready,
    input  bsf_pkg::sts_t  sts,
    output bsf_pkg::cmd_t  cmd
);

    bsf_pkg::state_t state_reg, state_next;
    logic [2:0] term_reg, term_next;
    logic [1:0] sec_reg, sec_next;
    logic       out_valid_reg, out_valid_next;
    logic       out_free;
    logic       last_sec;

    assign out_free = !out_valid_reg || out_ready;
    assign last_sec = (sec_reg == (sts.cascade ? bsf_pkg::SEC_HP2 : bsf_pkg::SEC_HP1));
    assign out_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= bsf_pkg::ST_IDLE;
            term_reg      <= '0;
            sec_reg       <= bsf_pkg::SEC_LP1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            term_reg      <= term_next;
            sec_reg       <= sec_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Next state and step counters
    always_comb
    begin
        state_next = state_reg;
        term_next  = term_reg;
        sec_next   = sec_reg;
        unique case (state_reg)
            bsf_pkg::ST_IDLE:
            begin
                term_next = '0;
                sec_next  = bsf_pkg::SEC_LP1;
                if (in_valid)
                begin
                    state_next = (kind == bsf_pkg::KIND_CLEAR) ? bsf_pkg::ST_CLEAR
                                                               : bsf_pkg::ST_MAC;
                end
            end
            bsf_pkg::ST_MAC:
            begin
                if (term_reg == bsf_pkg::MAC_LAST)
                    state_next = bsf_pkg::ST_ROUND;
                else
                    term_next = term_reg + 3'd1;
            end
            bsf_pkg::ST_ROUND:
            begin
                if (last_sec)
                    state_next = bsf_pkg::ST_SUM;
                else
                begin
                    state_next = bsf_pkg::ST_MAC;
                    term_next  = '0;
                    sec_next   = sec_reg + 2'd1;
                end
            end
            bsf_pkg::ST_CLEAR:
            begin
                state_next = bsf_pkg::ST_SUM;
            end
            bsf_pkg::ST_SUM:
            begin
                if (out_free)
                    state_next = bsf_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = bsf_pkg::ST_IDLE;
            end
        endcase
    end

    // Outputs and datapath commands
    always_comb
    begin
        in_ready      = 1'b0;
        cmd           = '0;
        cmd.term      = bsf_pkg::TERM_X0;
        cmd.sec       = sec_reg;
        out_valid_next = out_valid_reg && !out_ready;
        unique case (state_reg)
            bsf_pkg::ST_IDLE:
            begin
                in_ready   = 1'b1;
                cmd.load_x = in_valid;
            end
            bsf_pkg::ST_MAC:
            begin
                cmd.mul_en    = (term_reg != bsf_pkg::MAC_LAST);
                if (term_reg != bsf_pkg::MAC_LAST)
                    cmd.term = bsf_pkg::term_t'(term_reg);
                cmd.acc_en    = (term_reg != 3'd0);
                cmd.acc_first = (term_reg == 3'd1);
            end
            bsf_pkg::ST_ROUND:
            begin
                cmd.round_en = 1'b1;
            end
            bsf_pkg::ST_CLEAR:
            begin
                cmd.clear = 1'b1;
            end
            bsf_pkg::ST_SUM:
            begin
                cmd.sum_en = out_free;
                if (out_free)
                    out_valid_next = 1'b1;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> state_reg != bsf_pkg::ST_IDLE)
        else $error("accepted transaction did not start work");

    a_sum_raises_valid: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == bsf_pkg::ST_SUM && out_free |=> out_valid)
        else $error("result not presented after sum");

    a_no_cascade_stage: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == bsf_pkg::ST_MAC && !sts.cascade |-> sec_reg[1] == 1'b0)
        else $error("second stage run without cascade");

    a_term_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == bsf_pkg::ST_MAC |-> term_reg <= bsf_pkg::MAC_LAST)
        else $error("MAC step counter out of range");

endmodule

// ----- design/bsf_datapath.sv -----
module bsf_datapath #(
    parameter int SAMPLE_BITS         = 16,
    parameter int COEF_FRAC_BITS      = 18,
    parameter int SECTIONS_PER_BRANCH = 2
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_wr_en,
    input  logic [bsf_pkg::CFG_INDEX_BITS-1:0]     cfg_index,
    input  logic [bsf_pkg::COEF_BITS-1:0]          cfg_data,
    input  logic signed [SAMPLE_BITS-1:0]          sample_in,
    input  bsf_pkg::cmd_t                          cmd,
    output bsf_pkg::sts_t                          sts,
    output logic signed [SAMPLE_BITS-1:0]          stop_out,
    output logic signed [SAMPLE_BITS-1:0]          low_out,
    output logic signed [SAMPLE_BITS-1:0]          high_out
);

    localparam int NSEC      = 2 * SECTIONS_PER_BRANCH;
    localparam int IDX_BITS  = $clog2(NSEC);
    localparam int PROD_BITS = bsf_pkg::COEF_BITS + SAMPLE_BITS;
    localparam int ACC_BITS  = PROD_BITS + 3;

    localparam logic signed [ACC_BITS-1:0] SMAX =
        {{(ACC_BITS-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [ACC_BITS-1:0] SMIN = ~SMAX;
    localparam logic signed [ACC_BITS-1:0] HALF =
        ACC_BITS'(1) << (COEF_FRAC_BITS - 1);
    localparam logic signed [SAMPLE_BITS:0] SUM_MAX =
        {2'b00, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [SAMPLE_BITS:0] SUM_MIN = ~SUM_MAX;

    logic signed [bsf_pkg::COEF_BITS-1:0] low_b0_reg, low_a1_reg, low_a2_reg;
    logic signed [bsf_pkg::COEF_BITS-1:0] high_b0_reg, high_a1_reg, high_a2_reg;
    logic                                 fourth_order_reg;

    logic signed [SAMPLE_BITS-1:0] x_reg;
    logic signed [SAMPLE_BITS-1:0] lo_reg, hi_reg;
    logic signed [SAMPLE_BITS-1:0] xh0_reg [NSEC];
    logic signed [SAMPLE_BITS-1:0] xh1_reg [NSEC];
    logic signed [SAMPLE_BITS-1:0] yh0_reg [NSEC];
    logic signed [SAMPLE_BITS-1:0] yh1_reg [NSEC];

    logic signed [PROD_BITS-1:0] prod_reg, prod_next;
    bsf_pkg::term_t              prod_term_reg;
    logic                        prod_branch_reg;
    logic signed [ACC_BITS-1:0]  acc_reg, acc_next;

    logic signed [SAMPLE_BITS-1:0] stop_reg, low_out_reg, high_out_reg;

    logic                                 branch;
    logic [IDX_BITS-1:0]                  idx;
    logic signed [SAMPLE_BITS-1:0]        xin;
    logic signed [bsf_pkg::COEF_BITS-1:0] coef_sel;
    logic signed [SAMPLE_BITS-1:0]        op_sel;
    logic signed [ACC_BITS-1:0]           term_ext, term_adj;
    logic signed [ACC_BITS-1:0]           acc_rnd, acc_shift;
    logic signed [SAMPLE_BITS-1:0]        y_sat;
    logic signed [SAMPLE_BITS:0]          sum_wide;
    logic signed [SAMPLE_BITS-1:0]        sum_sat;

    assign sts.cascade = (SECTIONS_PER_BRANCH >= 2) && fourth_order_reg;
    assign stop_out    = stop_reg;
    assign low_out     = low_out_reg;
    assign high_out    = high_out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_b0_reg       <= '0;
            low_a1_reg       <= '0;
            low_a2_reg       <= '0;
            high_b0_reg      <= '0;
            high_a1_reg      <= '0;
            high_a2_reg      <= '0;
            fourth_order_reg <= 1'b0;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                bsf_pkg::CFG_LOW_B0:       low_b0_reg       <= cfg_data;
                bsf_pkg::CFG_LOW_A1:       low_a1_reg       <= cfg_data;
                bsf_pkg::CFG_LOW_A2:       low_a2_reg       <= cfg_data;
                bsf_pkg::CFG_HIGH_B0:      high_b0_reg      <= cfg_data;
                bsf_pkg::CFG_HIGH_A1:      high_a1_reg      <= cfg_data;
                bsf_pkg::CFG_HIGH_A2:      high_a2_reg      <= cfg_data;
                bsf_pkg::CFG_FOURTH_ORDER: fourth_order_reg <= cfg_data[0];
                default:                   fourth_order_reg <= fourth_order_reg;
            endcase
        end
    end

    // Section operand selection
    assign branch = cmd.sec[0];
    assign idx    = cmd.sec[IDX_BITS-1:0];
    assign xin    = !cmd.sec[1] ? x_reg : (branch ? hi_reg : lo_reg);

    always_comb
    begin
        unique case (cmd.term)
            bsf_pkg::TERM_X0:
            begin
                coef_sel = branch ? high_b0_reg : low_b0_reg;
                op_sel   = xin;
            end
            bsf_pkg::TERM_X1:
            begin
                coef_sel = branch ? high_b0_reg : low_b0_reg;
                op_sel   = xh0_reg[idx];
            end
            bsf_pkg::TERM_X2:
            begin
                coef_sel = branch ? high_b0_reg : low_b0_reg;
                op_sel   = xh1_reg[idx];
            end
            bsf_pkg::TERM_Y1:
            begin
                coef_sel = branch ? high_a1_reg : low_a1_reg;
                op_sel   = yh0_reg[idx];
            end
            bsf_pkg::TERM_Y2:
            begin
                coef_sel = branch ? high_a2_reg : low_a2_reg;
                op_sel   = yh1_reg[idx];
            end
            default:
            begin
                coef_sel = '0;
                op_sel   = '0;
            end
        endcase
    end

    assign prod_next = PROD_BITS'(coef_sel) * PROD_BITS'(op_sel);

    // b1 is +2*b0 on the low branch and -2*b0 on the high branch; feedback subtracts
    always_comb
    begin
        term_ext = ACC_BITS'(prod_reg);
        case (prod_term_reg)
            bsf_pkg::TERM_X1:
                term_adj = prod_branch_reg ? -(term_ext <<< 1) : (term_ext <<< 1);
            bsf_pkg::TERM_Y1, bsf_pkg::TERM_Y2:
                term_adj = -term_ext;
            default:
                term_adj = term_ext;
        endcase
    end

    assign acc_next = (cmd.acc_first ? '0 : acc_reg) + term_adj;

    // Round half up, floor shift, saturate
    assign acc_rnd   = acc_reg + HALF;
    assign acc_shift = acc_rnd >>> COEF_FRAC_BITS;

    always_comb
    begin
        if (acc_shift > SMAX)
            y_sat = SMAX[SAMPLE_BITS-1:0];
        else if (acc_shift < SMIN)
            y_sat = SMIN[SAMPLE_BITS-1:0];
        else
            y_sat = acc_shift[SAMPLE_BITS-1:0];
    end

    assign sum_wide = (SAMPLE_BITS+1)'(lo_reg) + (SAMPLE_BITS+1)'(hi_reg);

    always_comb
    begin
        if (sum_wide > SUM_MAX)
            sum_sat = SUM_MAX[SAMPLE_BITS-1:0];
        else if (sum_wide < SUM_MIN)
            sum_sat = SUM_MIN[SAMPLE_BITS-1:0];
        else
            sum_sat = sum_wide[SAMPLE_BITS-1:0];
    end

    // Sample capture, multiply-accumulate pipeline and output registers
    always_ff @(posedge clk)
    begin
        if (cmd.load_x)
            x_reg <= sample_in;
        if (cmd.mul_en)
        begin
            prod_reg        <= prod_next;
            prod_term_reg   <= cmd.term;
            prod_branch_reg <= branch;
        end
        if (cmd.acc_en)
            acc_reg <= acc_next;
        if (cmd.sum_en)
        begin
            stop_reg     <= sum_sat;
            low_out_reg  <= lo_reg;
            high_out_reg <= hi_reg;
        end
    end

    // Section history and branch results
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lo_reg <= '0;
            hi_reg <= '0;
            for (int i = 0; i < NSEC; i++)
            begin
                xh0_reg[i] <= '0;
                xh1_reg[i] <= '0;
                yh0_reg[i] <= '0;
                yh1_reg[i] <= '0;
            end
        end
        else if (cmd.clear)
        begin
            lo_reg <= '0;
            hi_reg <= '0;
            for (int i = 0; i < NSEC; i++)
            begin
                xh0_reg[i] <= '0;
                xh1_reg[i] <= '0;
                yh0_reg[i] <= '0;
                yh1_reg[i] <= '0;
            end
        end
        else if (cmd.round_en)
        begin
            if (branch)
                hi_reg <= y_sat;
            else
                lo_reg <= y_sat;
            xh1_reg[idx] <= xh0_reg[idx];
            xh0_reg[idx] <= xin;
            yh1_reg[idx] <= yh0_reg[idx];
            yh0_reg[idx] <= y_sat;
        end
    end

endmodule

// ----- design/butterworth_band_stop_filter.sv -----
// Band-stop filter: low-pass plus high-pass direct-form-I biquad branches.
// Input channel (in_valid/in_ready) carries kind and sample_in; a sample
// transaction filters one Q15 sample, a clear transaction zeroes all section
// history and returns an all-zero result. Output channel (out_valid/out_ready)
// carries stop_out, low_out and high_out, one result per input transaction.
// Coefficients (Q2.18) and the order select are written through cfg_wr_en,
// cfg_index and cfg_data; the user must write them only while the block is
// idle, which the block itself does not enforce; writes take effect at once.
// One shared 20 x SAMPLE_BITS multiplier does all products, one per cycle:
// each section runs 5 products, a trailing accumulate, a round and history
// update. A sample transaction runs N sections, N = 2 at second order or 4 at
// fourth order, then a sum step; a clear transaction runs a clear step, then
// a sum step. The result sits in an output register; while the receiver stalls
// a new transaction can still be accepted and worked on, and the block holds
// its next result until the register frees up.
// Reset clears all coefficients, the order select and the section history.
module butterworth_band_stop_filter #(
    parameter int SAMPLE_BITS         = 16,
    parameter int COEF_FRAC_BITS      = 18,
    parameter int SECTIONS_PER_BRANCH = 2
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // Configuration write port
    input  logic                               cfg_wr_en,
    input  logic [bsf_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [bsf_pkg::COEF_BITS-1:0]      cfg_data,
    // Input channel
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic                               kind,
    input  logic signed [SAMPLE_BITS-1:0]      sample_in,
    // Output channel
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic signed [SAMPLE_BITS-1:0]      stop_out,
    output logic signed [SAMPLE_BITS-1:0]      low_out,
    output logic signed [SAMPLE_BITS-1:0]      high_out
);

    bsf_pkg::cmd_t cmd;
    bsf_pkg::sts_t sts;

    // Sequencer: accepts transactions, steps the MAC through each section,
    // and owns the output valid flag.
    bsf_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .kind      (kind),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    // Datapath: coefficient registers, shared multiplier, accumulator,
    // rounding/saturation, section history and the output register.
    bsf_datapath #(
        .SAMPLE_BITS         (SAMPLE_BITS),
        .COEF_FRAC_BITS      (COEF_FRAC_BITS),
        .SECTIONS_PER_BRANCH (SECTIONS_PER_BRANCH)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .sample_in (sample_in),
        .cmd       (cmd),
        .sts       (sts),
        .stop_out  (stop_out),
        .low_out   (low_out),
        .high_out  (high_out)
    );

endmodule
